// File: hdl/gso_pkg.sv
// ----------------------------------------------------------------------------
// gso_pkg
// Shared types and constants for the Gram-Schmidt orthonormalizer.
// ----------------------------------------------------------------------------
package gso_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = 6;
    localparam int DIM_W       = 4;
    localparam int IDX_W       = 3;
    localparam int DATA_W      = 32;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [ADDR_W-1:0] addr;
        logic              last;
        logic [DIM_W-1:0]  rows;
        logic [DIM_W-1:0]  cols;
    } gso_item_t;

endpackage

// File: hdl/gso_front.sv
// ----------------------------------------------------------------------------
// gso_front
// Holds the size registers, counts loaded elements and tags each beat with
// its store address and an end-of-matrix mark.
// ----------------------------------------------------------------------------
module gso_front #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [gso_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gso_pkg::DIM_W-1:0]    cfg_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [gso_pkg::DATA_W-1:0]   s_tdata,
    output logic                         push,
    output gso_pkg::gso_item_t           push_item,
    input  logic                         q_full
);
    import gso_pkg::*;

    logic [DIM_W-1:0] rows_cfg_reg, cols_cfg_reg;
    logic [DIM_W-1:0] rows_c, cols_c;
    logic [6:0]       load_count_reg, load_count_next, cnt_inc, total;
    logic             is_last;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign push      = s_tvalid && s_tready;

    always_comb begin
        if (rows_cfg_reg == '0)                 rows_c = DIM_W'(1);
        else if (rows_cfg_reg > DIM_W'(MAX_ROWS)) rows_c = DIM_W'(MAX_ROWS);
        else                                    rows_c = rows_cfg_reg;
        if (cols_cfg_reg == '0)                 cols_c = DIM_W'(1);
        else if (cols_cfg_reg > DIM_W'(MAX_COLS)) cols_c = DIM_W'(MAX_COLS);
        else                                    cols_c = cols_cfg_reg;
        total           = 7'(rows_c) * 7'(cols_c);
        cnt_inc         = load_count_reg + 7'd1;
        is_last         = cnt_inc >= total;
        load_count_next = is_last ? 7'd0 : cnt_inc;
    end

    assign push_item = '{value: s_tdata, addr: load_count_reg[ADDR_W-1:0],
                         last: is_last, rows: rows_c, cols: cols_c};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg   <= DIM_W'(4);
            cols_cfg_reg   <= DIM_W'(4);
            load_count_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_ROWS: rows_cfg_reg <= cfg_data;
                    REG_COLS: cols_cfg_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (push) load_count_reg <= load_count_next;
        end
    end

endmodule

// File: hdl/gso_queue.sv
// ----------------------------------------------------------------------------
// gso_queue
// Four-entry queue between the load front and the compute back.
// ----------------------------------------------------------------------------
module gso_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  gso_pkg::gso_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output gso_pkg::gso_item_t pop_item
);
    import gso_pkg::*;

    gso_item_t  slot_reg [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] fill_reg;

    assign full      = fill_reg == 3'd4;
    assign not_empty = fill_reg != 3'd0;
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 2'd1;
            fill_reg <= fill_reg + 3'(push) - 3'(pop);
        end
    end

endmodule

// File: hdl/gso_back.sv
// ----------------------------------------------------------------------------
// gso_back
// Matrix store and sequencer: loads elements, runs modified Gram-Schmidt
// with one shared multiplier, square root and divider, then streams results.
// ----------------------------------------------------------------------------
module gso_back #(
    parameter int FRAC_BITS = 30
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_not_empty,
    input  gso_pkg::gso_item_t         q_item,
    output logic                       pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [39:0]                m_tdata,
    output logic                       m_tuser,
    output logic                       m_tlast
);
    import gso_pkg::*;

    localparam logic [3:0] S_LOAD = 4'd0, S_DOT_RD = 4'd1, S_DOT_MUL = 4'd2,
        S_DOT_ACC = 4'd3, S_DOT_END = 4'd4, S_UPD_RD = 4'd5, S_UPD_MUL = 4'd6,
        S_UPD_WR = 4'd7, S_SQRT = 4'd8, S_NRM_RD = 4'd9, S_NRM_INIT = 4'd10,
        S_NRM_DIV = 4'd11, S_NRM_WR = 4'd12, S_ZERO_WR = 4'd13, S_OUT_RD = 4'd14,
        S_OUT_SEND = 4'd15;

    localparam logic signed [63:0] HALF  = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [63:0] MAX32 = 64'sd2147483647;
    localparam logic signed [63:0] MIN32 = -64'sd2147483648;

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] round_shr(input logic signed [63:0] x);
        return sat_add64(x, HALF) >>> FRAC_BITS;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] x);
        if (x > MAX32) return 32'h7fff_ffff;
        if (x < MIN32) return 32'h8000_0000;
        return x[31:0];
    endfunction

    logic [DATA_W-1:0]  mem [STORE_DEPTH];
    logic [DATA_W-1:0]  rd_a_reg, rd_b_reg;
    logic [ADDR_W-1:0]  ra, rb, wa;
    logic [DATA_W-1:0]  wd;
    logic               we;

    logic [3:0]         state_reg;
    logic [IDX_W-1:0]   i_reg, p_reg, j_reg;
    logic               self_reg;
    logic [DIM_W-1:0]   rows_reg, cols_reg;
    logic signed [63:0] acc_reg, prod_reg;
    logic [31:0]        coef_reg;
    logic [63:0]        sq_v_reg, res_reg, bit_reg;
    logic               neg_reg;
    logic [63:0]        num_reg, quot_reg;
    logic [64:0]        rem_reg;
    logic [5:0]         cnt_reg;
    logic [7:0]         zero_row_reg;
    logic               o_valid_reg, o_last_reg;
    logic [39:0]        o_data_reg;
    logic               o_user_reg;

    logic               j_end, i_end;
    logic               out_load;
    logic [63:0]        sq_try;
    logic [64:0]        rem_sh;
    logic [31:0]        mag_a;
    logic [31:0]        nrm_val;
    logic signed [63:0] upd_diff;

    assign ra    = ADDR_W'({3'b0, p_reg} * {2'b0, cols_reg}) + ADDR_W'(j_reg);
    assign rb    = ADDR_W'({3'b0, i_reg} * {2'b0, cols_reg}) + ADDR_W'(j_reg);
    assign j_end = {1'b0, j_reg} == cols_reg - DIM_W'(1);
    assign i_end = {1'b0, i_reg} == rows_reg - DIM_W'(1);
    assign pop   = (state_reg == S_LOAD) && q_not_empty;
    // output register takes a new beat when empty or being drained
    assign out_load = (state_reg == S_OUT_SEND) && (!o_valid_reg || m_tready);

    always_comb begin
        sq_try   = res_reg + bit_reg;
        rem_sh   = {rem_reg[63:0], num_reg[63]};
        mag_a    = rd_b_reg[31] ? 32'(-{1'b1, rd_b_reg}) : rd_b_reg;
        upd_diff = {{32{rd_b_reg[31]}}, rd_b_reg} - round_shr(prod_reg);
        // sign-apply and saturate the rounded quotient
        if (neg_reg) nrm_val = (quot_reg > 64'h8000_0000) ? 32'h8000_0000
                                                          : 32'(-quot_reg);
        else         nrm_val = (quot_reg > 64'h7fff_ffff) ? 32'h7fff_ffff
                                                          : quot_reg[31:0];
        we = 1'b0;
        wa = rb;
        wd = '0;
        unique case (state_reg)
            S_LOAD: begin
                we = pop;
                wa = q_item.addr;
                wd = q_item.value;
            end
            S_UPD_WR: begin
                we = 1'b1;
                wd = sat32(upd_diff);
            end
            S_NRM_WR: begin
                we = 1'b1;
                wd = nrm_val;
            end
            S_ZERO_WR: we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) mem[wa] <= wd;
        rd_a_reg <= mem[ra];
        rd_b_reg <= mem[rb];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_LOAD;
            o_valid_reg  <= 1'b0;
            zero_row_reg <= '0;
        end else begin
            if (out_load)      o_valid_reg <= 1'b1;
            else if (m_tready) o_valid_reg <= 1'b0;
            unique case (state_reg)
                S_LOAD: begin
                    if (pop && q_item.last) begin
                        rows_reg  <= q_item.rows;
                        cols_reg  <= q_item.cols;
                        i_reg     <= '0;
                        p_reg     <= '0;
                        j_reg     <= '0;
                        self_reg  <= 1'b1;
                        acc_reg   <= '0;
                        state_reg <= S_DOT_RD;
                    end
                end
                S_DOT_RD:  state_reg <= S_DOT_MUL;
                S_DOT_MUL: begin
                    prod_reg  <= $signed(rd_a_reg) * $signed(rd_b_reg);
                    state_reg <= S_DOT_ACC;
                end
                S_DOT_ACC: begin
                    acc_reg <= sat_add64(acc_reg, prod_reg);
                    if (j_end) state_reg <= S_DOT_END;
                    else begin
                        j_reg     <= j_reg + IDX_W'(1);
                        state_reg <= S_DOT_RD;
                    end
                end
                S_DOT_END: begin
                    j_reg <= '0;
                    if (self_reg) begin
                        sq_v_reg  <= acc_reg[63] ? 64'd0 : acc_reg;
                        res_reg   <= '0;
                        bit_reg   <= 64'd1 << 62;
                        state_reg <= S_SQRT;
                    end else begin
                        coef_reg  <= sat32(round_shr(acc_reg));
                        state_reg <= S_UPD_RD;
                    end
                end
                S_UPD_RD:  state_reg <= S_UPD_MUL;
                S_UPD_MUL: begin
                    prod_reg  <= $signed(coef_reg) * $signed(rd_a_reg);
                    state_reg <= S_UPD_WR;
                end
                S_UPD_WR: begin
                    if (j_end) begin
                        j_reg   <= '0;
                        acc_reg <= '0;
                        if (p_reg + IDX_W'(1) == i_reg) self_reg <= 1'b1;
                        p_reg     <= p_reg + IDX_W'(1);
                        state_reg <= S_DOT_RD;
                    end else begin
                        j_reg     <= j_reg + IDX_W'(1);
                        state_reg <= S_UPD_RD;
                    end
                end
                S_SQRT: begin
                    if (bit_reg == '0) begin
                        zero_row_reg[i_reg] <= res_reg == '0;
                        state_reg <= (res_reg == '0) ? S_ZERO_WR : S_NRM_RD;
                    end else begin
                        if (sq_v_reg >= sq_try) begin
                            sq_v_reg <= sq_v_reg - sq_try;
                            res_reg  <= (res_reg >> 1) + bit_reg;
                        end else begin
                            res_reg <= res_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                    end
                end
                S_NRM_RD:   state_reg <= S_NRM_INIT;
                S_NRM_INIT: begin
                    neg_reg   <= rd_b_reg[31];
                    num_reg   <= ({32'd0, mag_a} << FRAC_BITS) + (res_reg >> 1);
                    rem_reg   <= '0;
                    quot_reg  <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_NRM_DIV;
                end
                S_NRM_DIV: begin
                    // restoring division, one quotient bit per cycle
                    num_reg <= num_reg << 1;
                    if (rem_sh >= {1'b0, res_reg}) begin
                        rem_reg  <= rem_sh - {1'b0, res_reg};
                        quot_reg <= {quot_reg[62:0], 1'b1};
                    end else begin
                        rem_reg  <= rem_sh;
                        quot_reg <= {quot_reg[62:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63) state_reg <= S_NRM_WR;
                end
                S_NRM_WR, S_ZERO_WR: begin
                    if (!j_end) begin
                        j_reg     <= j_reg + IDX_W'(1);
                        state_reg <= (state_reg == S_NRM_WR) ? S_NRM_RD : S_ZERO_WR;
                    end else begin
                        j_reg <= '0;
                        if (i_end) begin
                            i_reg     <= '0;
                            state_reg <= S_OUT_RD;
                        end else begin
                            i_reg     <= i_reg + IDX_W'(1);
                            p_reg     <= '0;
                            self_reg  <= 1'b0;
                            acc_reg   <= '0;
                            state_reg <= S_DOT_RD;
                        end
                    end
                end
                S_OUT_RD:   state_reg <= S_OUT_SEND;
                S_OUT_SEND: begin
                    if (out_load) begin
                        o_data_reg  <= {2'b00, j_reg, i_reg, rd_b_reg};
                        o_user_reg  <= zero_row_reg[i_reg];
                        o_last_reg  <= i_end && j_end;
                        if (j_end) begin
                            j_reg     <= '0;
                            i_reg     <= i_reg + IDX_W'(1);
                            state_reg <= i_end ? S_LOAD : S_OUT_RD;
                        end else begin
                            j_reg     <= j_reg + IDX_W'(1);
                            state_reg <= S_OUT_RD;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_data_reg;
    assign m_tuser  = o_user_reg;
    assign m_tlast  = o_last_reg;

endmodule

// File: hdl/gram_schmidt_orthonormalizer_top.sv
// ----------------------------------------------------------------------------
// gram_schmidt_orthonormalizer_top
// Fixed-point modified Gram-Schmidt row orthonormalizer.
//
//   channel  dir  handshake              payload
//   cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//   s        in   s_tvalid / s_tready    s_tdata
//   m        out  m_tvalid / m_tready    m_tdata, m_tuser, m_tlast
//
// loading takes one element per cycle while the four-entry queue has room; the queue absorbs stalls
// a matrix is then processed in the shared multiplier, bit-pair square root
// and one-bit-per-cycle divider; each result beat is read from the store and
// then loaded into the output register
// new elements queue up while the sequencer works, then stall
// aresetn is synchronous; sizes return to 4x4 and the load count to zero
// ----------------------------------------------------------------------------
module gram_schmidt_orthonormalizer_top #(
    parameter int MAX_ROWS  = 8,
    parameter int MAX_COLS  = 8,
    parameter int FRAC_BITS = 30
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gso_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gso_pkg::DIM_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // element_value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata,   // result_value, row_index, col_index
    output logic                          m_tuser,   // zero_norm_row
    output logic                          m_tlast
);
    import gso_pkg::*;

    gso_item_t push_item, pop_item;
    logic      push, pop, q_full, q_not_empty;

    gso_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
        .aclk, .aresetn, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .s_tvalid, .s_tready, .s_tdata, .push, .push_item, .q_full
    );

    gso_queue u_queue (
        .aclk, .aresetn, .push, .push_item, .full(q_full), .pop,
        .not_empty(q_not_empty), .pop_item
    );

    gso_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk, .aresetn, .q_not_empty, .q_item(pop_item), .pop,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
    );

endmodule

// File: hdl/gso_checker.sv
// ----------------------------------------------------------------------------
// gso_checker
// Port-level checks on the orthonormalizer output stream.
// ----------------------------------------------------------------------------
module gso_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);
    // stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed under stall");

    // no output right after reset
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // zero-norm rows carry zeros
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[31:0] == 32'd0)
        else $error("zero-norm row with nonzero data");

    // beat after a last beat starts at row 0 column 0
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast ##1 m_tvalid |-> m_tdata[37:32] == 6'd0)
        else $error("matrix did not restart at origin");
endmodule

bind gram_schmidt_orthonormalizer_top gso_checker u_gso_checker (
    .aclk, .aresetn, .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
);

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the Gram-Schmidt orthonormalizer against a fixed-point predictor.
// Matrices are streamed in element by element. Every result beat is compared
// with the predicted value, indices, zero-norm flag and last mark. Sizes
// change between matrices and also in the middle of loads.
// ----------------------------------------------------------------------------
module testbench;
    import gso_pkg::*;

    localparam int  FRAC        = 30;
    localparam int  MAX_DIM     = 8;
    localparam int  IDLE_LIMIT  = 100000;
    localparam int  SETTLE      = 64;
    localparam int  ITEMS_PHASE = 100;

    localparam logic [31:0] ONE_Q   = 32'h4000_0000;
    localparam logic [31:0] MAX_Q   = 32'h7fff_ffff;
    localparam logic [31:0] MIN_Q   = 32'h8000_0000;
    localparam longint      HALF_LSB = longint'(1) <<< (FRAC - 1);

    typedef struct {
        logic [31:0]      value;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             zero_norm;
        logic             last;
    } gso_beat_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_ROWS;
    logic [DIM_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [39:0]          m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    // predictor state
    logic [31:0]      matrix_mem [STORE_DEPTH];
    logic [6:0]       load_cnt;
    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] cols_reg;
    gso_beat_t        expected_beats [$];

    int idle_pct;
    int stall_pct;
    int errors;
    int quiet_cycles;

    gram_schmidt_orthonormalizer_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // element_value
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // result_value, row_index, col_index
        .m_tuser   (m_tuser),    // zero_norm_row
        .m_tlast   (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ---------------- fixed-point arithmetic ----------------
    function automatic longint add_sat64(longint a, longint b);
        logic signed [64:0] s;
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    function automatic longint round_q(longint x);
        return add_sat64(x, HALF_LSB) >>> FRAC;
    endfunction

    function automatic int sat32(longint x);
        if (x > 64'sd2147483647) return 32'h7fff_ffff;
        if (x < -64'sd2147483648) return 32'h8000_0000;
        return int'(x);
    endfunction

    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = '0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic int scale_by_norm(int a, logic [63:0] mag);
        logic [63:0] mag_a;
        logic [63:0] q;
        mag_a = (a < 0) ? 64'(-longint'(a)) : 64'(longint'(a));
        q = ((mag_a << FRAC) + mag / 2) / mag;
        if (a < 0) return (q > 64'd2147483648) ? 32'h8000_0000 : sat32(-longint'(q));
        return (q > 64'd2147483647) ? 32'h7fff_ffff : int'(q);
    endfunction

    function automatic int dim_used(logic [DIM_W-1:0] r);
        if (r == 0) return 1;
        return (r > MAX_DIM) ? MAX_DIM : int'(r);
    endfunction

    function automatic int mem_at(int idx);
        return $signed(matrix_mem[idx % STORE_DEPTH]);
    endfunction

    function automatic longint row_dot(int ra, int rb, int cols);
        longint acc;
        acc = 0;
        for (int j = 0; j < cols; j++)
            acc = add_sat64(acc, longint'(mem_at(ra*cols + j)) * longint'(mem_at(rb*cols + j)));
        return acc;
    endfunction

    // store one element; on a full matrix orthonormalize and queue all beats
    function automatic void load_and_orthonormalize(logic [31:0] v);
        int          rows;
        int          cols;
        int          coef;
        longint      sq;
        logic [63:0] mag;
        bit          zero_row [MAX_DIM];
        gso_beat_t   b;
        rows = dim_used(rows_reg);
        cols = dim_used(cols_reg);
        matrix_mem[load_cnt[5:0]] = v;
        load_cnt = load_cnt + 7'd1;
        if (int'(load_cnt) < rows*cols) return;
        load_cnt = '0;
        for (int i = 0; i < rows; i++) begin
            for (int p = 0; p < i; p++) begin
                coef = sat32(round_q(row_dot(p, i, cols)));
                for (int j = 0; j < cols; j++)
                    matrix_mem[i*cols + j] = sat32(longint'(mem_at(i*cols + j))
                        - round_q(longint'(coef) * longint'(mem_at(p*cols + j))));
            end
            sq = row_dot(i, i, cols);
            mag = isqrt64(sq > 0 ? 64'(sq) : 64'd0);
            zero_row[i] = (mag == 0);
            for (int j = 0; j < cols; j++)
                matrix_mem[i*cols + j] = zero_row[i] ? 32'd0
                                                     : scale_by_norm(mem_at(i*cols + j), mag);
        end
        for (int i = 0; i < rows; i++) begin
            for (int j = 0; j < cols; j++) begin
                b.value     = matrix_mem[i*cols + j];
                b.row       = i[IDX_W-1:0];
                b.col       = j[IDX_W-1:0];
                b.zero_norm = zero_row[i];
                b.last      = (i == rows - 1) && (j == cols - 1);
                expected_beats.push_back(b);
            end
        end
    endfunction

    // ---------------- drivers ----------------
    // called and returning at a falling edge
    task automatic send_element(logic [31:0] v);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = v;
        do @(posedge aclk); while (!s_tready);
        load_and_orthonormalize(v);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
        wait (expected_beats.size() == 0);
        repeat (SETTLE) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_ROWS) rows_reg = val;
        else cols_reg = val;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] random_element();
        int unsigned pick;
        logic [31:0] v;
        pick = $urandom_range(15);
        if (pick == 0) return '0;
        if (pick == 1) return MAX_Q;
        if (pick == 2) return MIN_Q;
        if (pick < 6) return $urandom;
        v = $urandom >> $urandom_range(1, 12);
        return $urandom_range(1) ? -v : v;
    endfunction

    // whole matrix; some rows are zero or copies of the row above
    task automatic send_matrix(int rows, int cols);
        logic [31:0] prev_row [MAX_DIM];
        logic [31:0] v;
        int unsigned kind;
        for (int i = 0; i < rows; i++) begin
            kind = $urandom_range(9);
            for (int j = 0; j < cols; j++) begin
                if (kind == 0) v = '0;
                else if (kind == 1 && i > 0) v = prev_row[j];
                else v = random_element();
                prev_row[j] = v;
                send_element(v);
            end
        end
    endtask

    // ---------------- result checking ----------------
    always @(negedge aclk) begin
        if (aresetn) m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        gso_beat_t e;
        if (m_tvalid && m_tready) begin
            if (expected_beats.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: data %h user %b last %b",
                             m_tdata, m_tuser, m_tlast);
            end else begin
                e = expected_beats.pop_front();
                if (m_tdata !== {2'b00, e.col, e.row, e.value} || m_tuser !== e.zero_norm
                        || m_tlast !== e.last) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch row %0d col %0d: exp %h zero %b last %b",
                                 e.row, e.col, e.value, e.zero_norm, e.last,
                                 ", got %h user %b last %b", m_tdata, m_tuser, m_tlast);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAIL gram_schmidt_orthonormalizer_top");
            $finish;
        end
    end

    // ---------------- tests ----------------
    // default 4x4: unit row, extremes, zero row, dependent row
    task automatic test_default_size();
        logic [31:0] m [16] = '{ONE_Q, 32'd0, 32'd0, 32'd0,
                                MAX_Q, MIN_Q, MAX_Q, MIN_Q,
                                32'd0, 32'd0, 32'd0, 32'd0,
                                ONE_Q, 32'd0, 32'd0, 32'd0};
        foreach (m[k]) send_element(m[k]);
    endtask

    // zero registers count as one
    task automatic test_single_element();
        write_reg(REG_ROWS, 4'd0);
        write_reg(REG_COLS, 4'd0);
        send_element(MAX_Q);
        send_element(MIN_Q);
    endtask

    // size shrinks while elements are already loaded
    task automatic test_resize_mid_load();
        write_reg(REG_ROWS, 4'd2);
        write_reg(REG_COLS, 4'd3);
        repeat (4) send_element(random_element());
        write_reg(REG_COLS, 4'd1);
        send_element(random_element());
    endtask

    task automatic test_random_matrices(int idle, int stall);
        int sent;
        int rows;
        int cols;
        logic [DIM_W-1:0] r;
        logic [DIM_W-1:0] c;
        idle_pct  = idle;
        stall_pct = stall;
        sent = 0;
        while (sent < ITEMS_PHASE) begin
            if ($urandom_range(7) == 0) begin
                r = DIM_W'($urandom_range(15));
                c = DIM_W'($urandom_range(15));
            end else begin
                r = DIM_W'($urandom_range(1, 4));
                c = DIM_W'($urandom_range(1, 4));
            end
            write_reg(REG_ROWS, r);
            write_reg(REG_COLS, c);
            rows = dim_used(r);
            cols = dim_used(c);
            if ($urandom_range(9) == 0 && rows*cols > 1) begin
                // broken load: part of a matrix, then a new size
                repeat ($urandom_range(1, rows*cols - 1)) begin
                    send_element(random_element());
                    sent++;
                end
                write_reg(REG_COLS, DIM_W'($urandom_range(1, 4)));
                while (load_cnt != 0) begin
                    send_element(random_element());
                    sent++;
                end
            end else begin
                send_matrix(rows, cols);
                sent += rows * cols;
            end
        end
    endtask

    initial begin
        idle_pct     = 0;
        stall_pct    = 0;
        errors       = 0;
        quiet_cycles = 0;
        load_cnt     = '0;
        rows_reg     = 4'd4;
        cols_reg     = 4'd4;
        foreach (matrix_mem[k]) matrix_mem[k] = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_default_size();
        test_single_element();
        test_resize_mid_load();
        write_reg(REG_ROWS, 4'd8);
        write_reg(REG_COLS, 4'd8);
        send_matrix(8, 8);
        test_random_matrices(0, 0);
        test_random_matrices(58, 0);
        test_random_matrices(0, 58);
        test_random_matrices(37, 37);

        wait (expected_beats.size() == 0);
        repeat (200) @(posedge aclk);
        if (errors == 0)
            $display("PASS gram_schmidt_orthonormalizer_top");
        else
            $display("FAIL gram_schmidt_orthonormalizer_top");
        $finish;
    end

endmodule

// File: filelist.f
hdl/gso_pkg.sv
hdl/gso_front.sv
hdl/gso_queue.sv
hdl/gso_back.sv
hdl/gram_schmidt_orthonormalizer_top.sv
hdl/gso_checker.sv
dv/testbench.sv
